FILE: rtl/core/hmm_viterbi_decoder_defines.svh
// ----------------------------------------------------------------------------
// HMM Viterbi decoder assertion macros
// Shared immediate-style wrappers for concurrent checks on clk / rst.
// ----------------------------------------------------------------------------
`ifndef HMM_VITERBI_DECODER_DEFINES_SVH
`define HMM_VITERBI_DECODER_DEFINES_SVH

// same-cycle implication
`define HVD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hvd check failed");

// next-cycle implication
`define HVD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hvd check failed");

`endif

FILE: rtl/core/hvd_pkg.sv
// ----------------------------------------------------------------------------
// hvd_pkg
// Codes, score constants and saturating log-domain arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hvd_pkg;

  localparam logic [2:0] OP_LOAD_INIT  = 3'd0;
  localparam logic [2:0] OP_LOAD_TRANS = 3'd1;
  localparam logic [2:0] OP_LOAD_EMIT  = 3'd2;
  localparam logic [2:0] OP_NEW_SEQ    = 3'd3;
  localparam logic [2:0] OP_OBSERVE    = 3'd4;
  localparam logic [2:0] OP_FINISH     = 3'd5;
  localparam logic [2:0] OP_READ_PATH  = 3'd6;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_POS   = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;

  localparam logic signed [31:0] NEG_INF   = 32'sh8000_0000;
  localparam logic signed [31:0] SCORE_MAX = 32'sh7FFF_FFFF;
  localparam logic [23:0] LOG_ZERO_CODE    = 24'h80_0000;

  function automatic logic signed [31:0] table_value(input logic [23:0] raw);
    logic signed [31:0] r;
    if (raw == LOG_ZERO_CODE) begin
      r = NEG_INF;
    end else begin
      r = {{8{raw[23]}}, raw};
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_add3(input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  input logic signed [31:0] c);
    logic signed [33:0] s;
    logic signed [31:0] r;
    s = 34'(a) + 34'(b) + 34'(c);
    if (a == NEG_INF || b == NEG_INF || c == NEG_INF) begin
      r = NEG_INF;
    end else if (s <= 34'(NEG_INF)) begin
      r = NEG_INF;
    end else if (s > 34'(SCORE_MAX)) begin
      r = SCORE_MAX;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/hmm_viterbi_decoder.sv
// ----------------------------------------------------------------------------
// hmm_viterbi_decoder
// Log-domain Viterbi decoder; tables, scores, backpointers and path in RAMs.
// ----------------------------------------------------------------------------
// Loads, new sequence and errors finish in S_EXEC; read path adds S_RD_WAIT.
// Observe: first symbol S_OBS0_RD, S_OBS0_WR per state; later S_OBS_EM, S_OBS_RUN,
//   S_OBS_WB per state, one add-compare per cycle (17689 pairs at default size).
// Finish: S_FIN_RUN, S_FIN_END, then S_TR_RD and S_TR_WR per traceback step.
// One beat in flight: busy until done, next beat accepted in the done cycle; no stall.
// Synchronous reset clears length and path flag; RAM contents are kept.
`timescale 1ns / 1ps

module hmm_viterbi_decoder #(
  parameter int N_STATES  = 133,
  parameter int N_SYMBOLS = 20,
  parameter int MAX_LEN   = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode,
  input  logic [7:0]         row_index,
  input  logic [7:0]         col_index,
  input  logic [4:0]         symbol,
  input  logic signed [23:0] log_value,
  input  logic [9:0]         position,
  output logic               done,
  output logic [2:0]         status,
  output logic [7:0]         path_state,
  output logic               path_found,
  output logic signed [31:0] best_score,
  output logic [10:0]        seq_count
);

  localparam int SI  = $clog2(N_STATES);
  localparam int CW  = $clog2(N_STATES + 1);
  localparam int SA  = $clog2(2 * N_STATES);
  localparam int TA  = $clog2(N_STATES * N_STATES);
  localparam int EA  = $clog2(N_STATES * N_SYMBOLS);
  localparam int BA  = $clog2(MAX_LEN * N_STATES);
  localparam int PA  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW  = $clog2(MAX_LEN + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_OBS0_RD, S_OBS0_WR, S_OBS_EM, S_OBS_RUN, S_OBS_WB,
    S_FIN_RUN, S_FIN_END, S_TR_RD, S_TR_WR, S_RD_WAIT
  } state_t;

  state_t state;

  logic [23:0] init_mem  [N_STATES];
  logic [23:0] trans_mem [N_STATES * N_STATES];
  logic [23:0] emit_mem  [N_STATES * N_SYMBOLS];
  logic [31:0] score_mem [2 * N_STATES];
  logic [7:0]  bp_mem    [MAX_LEN * N_STATES];
  logic [7:0]  path_mem  [(MAX_LEN > 1) ? MAX_LEN : 2];

  logic [2:0]  op_q;
  logic [7:0]  row_q, col_q;
  logic [4:0]  sym_q;
  logic [23:0] val_q;
  logic [9:0]  pos_q;

  logic [LW-1:0]   len;
  logic            path_ok;
  logic            bank;
  logic [BA:0]     bp_base;
  logic [BA:0]     tb_base;
  logic [SI-1:0]   i_idx;
  logic [CW-1:0]   l_iss;
  logic            rd_vld;
  logic [SI-1:0]   rd_l;
  logic [TA-1:0]   tr_addr;
  logic [EA-1:0]   em_addr;
  logic signed [31:0] best;
  logic [SI-1:0]   arg;
  logic [SI-1:0]   cur;
  logic [LW-1:0]   t_idx;

  logic [23:0] init_rd, trans_rd, emit_rd;
  logic [31:0] score_rd;
  logic [7:0]  bp_rd, path_rd;

  logic            score_we, path_we;
  logic [SA-1:0]   score_ra, score_wa;
  logic [31:0]     score_wd;
  logic [PA-1:0]   path_wa;
  logic [7:0]      path_wd;
  logic [SA-1:0]   prev_off, cur_off;
  logic signed [31:0] cand;
  logic            ld_init_ok, ld_trans_ok, ld_emit_ok;

  assign busy       = (state != S_IDLE);
  assign path_found = path_ok;
  assign seq_count  = 11'(len);

  assign prev_off = bank ? SA'(N_STATES) : '0;
  assign cur_off  = bank ? '0 : SA'(N_STATES);

  assign ld_init_ok  = (state == S_EXEC) && (op_q == hvd_pkg::OP_LOAD_INIT) &&
                       (32'(row_q) < N_STATES);
  assign ld_trans_ok = (state == S_EXEC) && (op_q == hvd_pkg::OP_LOAD_TRANS) &&
                       (32'(row_q) < N_STATES) && (32'(col_q) < N_STATES);
  assign ld_emit_ok  = (state == S_EXEC) && (op_q == hvd_pkg::OP_LOAD_EMIT) &&
                       (32'(row_q) < N_STATES) && (32'(sym_q) < N_SYMBOLS);

  always_comb begin
    score_ra = SA'(prev_off + SA'(l_iss[SI-1:0]));
    score_we = (state == S_OBS0_WR) || (state == S_OBS_WB);
    score_wa = SA'(cur_off + SA'(i_idx));
    if (state == S_OBS0_WR) begin
      score_wd = hvd_pkg::sat_add3(hvd_pkg::table_value(init_rd),
                                   hvd_pkg::table_value(emit_rd), 32'sd0);
    end else begin
      score_wd = best;
    end
    if (state == S_OBS_RUN) begin
      cand = hvd_pkg::sat_add3(score_rd, hvd_pkg::table_value(trans_rd),
                               hvd_pkg::table_value(emit_rd));
    end else begin
      cand = score_rd;
    end
    path_we = 1'b0;
    path_wa = PA'(len - 1'b1);
    path_wd = 8'(arg);
    if (state == S_FIN_END && best != hvd_pkg::NEG_INF) begin
      path_we = 1'b1;
    end else if (state == S_TR_WR) begin
      path_we = 1'b1;
      path_wa = PA'(t_idx - 1'b1);
      path_wd = bp_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_init_ok) begin
      init_mem[SI'(row_q)] <= val_q;
    end
    init_rd <= init_mem[i_idx];
  end

  always_ff @(posedge clk) begin
    if (ld_trans_ok) begin
      trans_mem[TA'(32'(row_q) * N_STATES + 32'(col_q))] <= val_q;
    end
    trans_rd <= trans_mem[tr_addr];
  end

  always_ff @(posedge clk) begin
    if (ld_emit_ok) begin
      emit_mem[EA'(32'(row_q) * N_SYMBOLS + 32'(sym_q))] <= val_q;
    end
    emit_rd <= emit_mem[em_addr];
  end

  always_ff @(posedge clk) begin
    if (score_we) begin
      score_mem[score_wa] <= score_wd;
    end
    score_rd <= score_mem[score_ra];
  end

  always_ff @(posedge clk) begin
    if (state == S_OBS_WB) begin
      bp_mem[BA'(bp_base + (BA+1)'(i_idx))] <= 8'(arg);
    end
    bp_rd <= bp_mem[BA'(tb_base + (BA+1)'(cur))];
  end

  always_ff @(posedge clk) begin
    if (path_we) begin
      path_mem[path_wa] <= path_wd;
    end
    path_rd <= path_mem[PA'(pos_q)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      len     <= '0;
      path_ok <= 1'b0;
      bank    <= 1'b0;
      bp_base <= '0;
      rd_vld  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_q  <= opcode;
            row_q <= row_index;
            col_q <= col_index;
            sym_q <= symbol;
            val_q <= log_value;
            pos_q <= position;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          status     <= hvd_pkg::ST_OK;
          path_state <= '0;
          best_score <= '0;
          i_idx      <= '0;
          l_iss      <= '0;
          rd_vld     <= 1'b0;
          tr_addr    <= '0;
          em_addr    <= EA'(sym_q);
          state      <= S_IDLE;
          done       <= 1'b1;
          case (op_q)
            hvd_pkg::OP_LOAD_INIT: begin
              if (!ld_init_ok) status <= hvd_pkg::ST_RANGE;
            end
            hvd_pkg::OP_LOAD_TRANS: begin
              if (!ld_trans_ok) status <= hvd_pkg::ST_RANGE;
            end
            hvd_pkg::OP_LOAD_EMIT: begin
              if (!ld_emit_ok) status <= hvd_pkg::ST_RANGE;
            end
            hvd_pkg::OP_NEW_SEQ: begin
              len     <= '0;
              path_ok <= 1'b0;
              bp_base <= '0;
            end
            hvd_pkg::OP_OBSERVE: begin
              if (32'(sym_q) >= N_SYMBOLS) begin
                status <= hvd_pkg::ST_RANGE;
              end else if (32'(len) >= MAX_LEN) begin
                status <= hvd_pkg::ST_FULL;
              end else begin
                done  <= 1'b0;
                state <= (len == '0) ? S_OBS0_RD : S_OBS_EM;
              end
            end
            hvd_pkg::OP_FINISH: begin
              if (len == '0) begin
                status <= hvd_pkg::ST_EMPTY;
              end else begin
                done  <= 1'b0;
                state <= S_FIN_RUN;
              end
            end
            hvd_pkg::OP_READ_PATH: begin
              if (LW'(pos_q) >= len || 32'(pos_q) >= MAX_LEN) begin
                status <= hvd_pkg::ST_POS;
              end else if (path_ok) begin
                done  <= 1'b0;
                state <= S_RD_WAIT;
              end
            end
            default: ;
          endcase
        end
        S_OBS0_RD: begin
          state <= S_OBS0_WR;
        end
        S_OBS0_WR: begin
          em_addr <= EA'(em_addr + EA'(N_SYMBOLS));
          i_idx   <= SI'(i_idx + 1'b1);
          state   <= S_OBS0_RD;
          if (32'(i_idx) == N_STATES - 1) begin
            len     <= LW'(len + 1'b1);
            bank    <= ~bank;
            bp_base <= (BA+1)'(bp_base + (BA+1)'(N_STATES));
            path_ok <= 1'b0;
            done    <= 1'b1;
            state   <= S_IDLE;
          end
        end
        S_OBS_EM: begin
          l_iss  <= '0;
          rd_vld <= 1'b0;
          state  <= S_OBS_RUN;
        end
        S_OBS_RUN, S_FIN_RUN: begin
          if (32'(l_iss) < N_STATES) begin
            rd_vld  <= 1'b1;
            rd_l    <= l_iss[SI-1:0];
            l_iss   <= CW'(l_iss + 1'b1);
            tr_addr <= TA'(tr_addr + TA'(N_STATES));
          end else begin
            rd_vld <= 1'b0;
          end
          if (rd_vld) begin
            if (rd_l == '0 || cand > best) begin
              best <= cand;
              arg  <= rd_l;
            end
            if (32'(rd_l) == N_STATES - 1) begin
              state <= (state == S_OBS_RUN) ? S_OBS_WB : S_FIN_END;
            end
          end
        end
        S_OBS_WB: begin
          i_idx   <= SI'(i_idx + 1'b1);
          tr_addr <= TA'(i_idx) + 1'b1;
          em_addr <= EA'(em_addr + EA'(N_SYMBOLS));
          state   <= S_OBS_EM;
          if (32'(i_idx) == N_STATES - 1) begin
            len     <= LW'(len + 1'b1);
            bank    <= ~bank;
            bp_base <= (BA+1)'(bp_base + (BA+1)'(N_STATES));
            path_ok <= 1'b0;
            done    <= 1'b1;
            state   <= S_IDLE;
          end
        end
        S_FIN_END: begin
          best_score <= best;
          if (best == hvd_pkg::NEG_INF) begin
            path_ok <= 1'b0;
            done    <= 1'b1;
            state   <= S_IDLE;
          end else begin
            path_state <= 8'(arg);
            cur        <= arg;
            t_idx      <= LW'(len - 1'b1);
            tb_base    <= (BA+1)'(bp_base - (BA+1)'(N_STATES));
            if (len == LW'(1)) begin
              path_ok <= 1'b1;
              done    <= 1'b1;
              state   <= S_IDLE;
            end else begin
              state <= S_TR_RD;
            end
          end
        end
        S_TR_RD: begin
          state <= S_TR_WR;
        end
        S_TR_WR: begin
          cur     <= SI'(bp_rd);
          t_idx   <= LW'(t_idx - 1'b1);
          tb_base <= (BA+1)'(tb_base - (BA+1)'(N_STATES));
          state   <= S_TR_RD;
          if (t_idx == LW'(1)) begin
            path_ok <= 1'b1;
            done    <= 1'b1;
            state   <= S_IDLE;
          end
        end
        S_RD_WAIT: begin
          path_state <= path_rd;
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/hvd_checker.sv
// ----------------------------------------------------------------------------
// hvd_checker
// Port-level checks on the decoder's command and result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hmm_viterbi_decoder_defines.svh"

module hvd_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [2:0]         opcode,
  input logic [7:0]         row_index,
  input logic [7:0]         col_index,
  input logic [4:0]         symbol,
  input logic signed [23:0] log_value,
  input logic [9:0]         position,
  input logic               done,
  input logic [2:0]         status,
  input logic [7:0]         path_state,
  input logic               path_found,
  input logic signed [31:0] best_score,
  input logic [10:0]        seq_count
);

  `HVD_ASSERT_NOW(a_done_idle, done, !busy)
  `HVD_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
  `HVD_ASSERT_NEXT(a_done_pulse, done, !done)
  `HVD_ASSERT_NOW(a_err_no_score, done && status != hvd_pkg::ST_OK, best_score == 32'sd0)
  `HVD_ASSERT_NOW(a_err_no_state, done && status != hvd_pkg::ST_OK, path_state == 8'd0)

endmodule

bind hmm_viterbi_decoder hvd_checker u_hvd_checker (.*);
